/* sv/sff_pkg.sv */
`timescale 1ns / 1ps
package sff_pkg;

  localparam int MAX_WIDTH_DEF  = 128;
  localparam int MAX_HEIGHT_DEF = 128;

  localparam int COORD_W = 8;    // active sizes are 8-bit registers
  localparam int BND_W   = 13;   // signed width of unclipped shape bounds
  localparam int DX_W    = 12;   // signed pixel offset from circle centre
  localparam int SQ_W    = 23;   // squared offset
  localparam int RR_W    = 20;   // squared radius
  localparam int STEP_W  = 4;
  localparam int COND_W  = 4;

  localparam logic [23:0] WHITE = 24'hFFFFFF;

  localparam logic [1:0] OP_RECT = 2'd0;
  localparam logic [1:0] OP_CIRC = 2'd1;
  localparam logic [1:0] OP_FILL = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  localparam logic CFG_ACTIVE_WIDTH  = 1'b0;
  localparam logic CFG_ACTIVE_HEIGHT = 1'b1;

  // sequencer branch conditions
  localparam logic [COND_W-1:0] C_NEXT     = 4'd0;
  localparam logic [COND_W-1:0] C_GOTO     = 4'd1;
  localparam logic [COND_W-1:0] C_WAIT     = 4'd2;
  localparam logic [COND_W-1:0] C_CLR_MORE = 4'd3;
  localparam logic [COND_W-1:0] C_OP_RD    = 4'd4;
  localparam logic [COND_W-1:0] C_OP_CIRC  = 4'd5;
  localparam logic [COND_W-1:0] C_EMPTY    = 4'd6;
  localparam logic [COND_W-1:0] C_X_MORE   = 4'd7;
  localparam logic [COND_W-1:0] C_Y_MORE   = 4'd8;

  // program addresses
  localparam logic [STEP_W-1:0] S_CLR   = 4'd0;
  localparam logic [STEP_W-1:0] S_IDLE  = 4'd1;
  localparam logic [STEP_W-1:0] S_DISP  = 4'd2;
  localparam logic [STEP_W-1:0] S_CHK   = 4'd3;
  localparam logic [STEP_W-1:0] S_ROW   = 4'd4;
  localparam logic [STEP_W-1:0] S_RPIX  = 4'd5;
  localparam logic [STEP_W-1:0] S_RNEXT = 4'd6;
  localparam logic [STEP_W-1:0] S_REND  = 4'd7;
  localparam logic [STEP_W-1:0] S_CSQ   = 4'd8;
  localparam logic [STEP_W-1:0] S_CPIX  = 4'd9;
  localparam logic [STEP_W-1:0] S_CNEXT = 4'd10;
  localparam logic [STEP_W-1:0] S_CEND  = 4'd11;
  localparam logic [STEP_W-1:0] S_RD    = 4'd12;
  localparam logic [STEP_W-1:0] S_RDOUT = 4'd13;

  typedef struct packed {
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] target;
    logic              idle;
    logic              clr;
    logic              setup;
    logic              y_init;
    logic              y_inc;
    logic              x_init;
    logic              x_inc;
    logic              sqy;
    logic              sqx;
    logic              wr;
    logic              circ;
    logic              rd;
    logic              out_stb;
  } ucode_t;

  typedef struct packed {
    logic clr_last;
    logic is_rd;
    logic is_circ;
    logic empty;
    logic x_more;
    logic y_more;
  } flags_t;

  function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '0;
    unique case (step)
      S_CLR: begin
        w.clr = 1'b1; w.cond = C_CLR_MORE; w.target = S_CLR;
      end
      S_IDLE: begin
        w.idle = 1'b1; w.cond = C_WAIT; w.target = S_IDLE;
      end
      S_DISP: begin
        w.setup = 1'b1; w.cond = C_OP_RD; w.target = S_RD;
      end
      S_CHK: begin
        w.y_init = 1'b1; w.cond = C_EMPTY; w.target = S_IDLE;
      end
      S_ROW: begin
        w.x_init = 1'b1; w.sqy = 1'b1; w.cond = C_OP_CIRC; w.target = S_CSQ;
      end
      S_RPIX: begin
        w.wr = 1'b1; w.x_inc = 1'b1; w.cond = C_X_MORE; w.target = S_RPIX;
      end
      S_RNEXT: begin
        w.y_inc = 1'b1; w.cond = C_Y_MORE; w.target = S_ROW;
      end
      S_REND: begin
        w.cond = C_GOTO; w.target = S_IDLE;
      end
      S_CSQ: begin
        w.sqx = 1'b1; w.cond = C_NEXT;
      end
      S_CPIX: begin
        w.wr = 1'b1; w.circ = 1'b1; w.x_inc = 1'b1;
        w.cond = C_X_MORE; w.target = S_CSQ;
      end
      S_CNEXT: begin
        w.y_inc = 1'b1; w.cond = C_Y_MORE; w.target = S_ROW;
      end
      S_CEND: begin
        w.cond = C_GOTO; w.target = S_IDLE;
      end
      S_RD: begin
        w.rd = 1'b1; w.cond = C_NEXT;
      end
      S_RDOUT: begin
        w.out_stb = 1'b1; w.cond = C_GOTO; w.target = S_IDLE;
      end
      default: begin
        w.cond = C_GOTO; w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* sv/sff_sequencer.sv */
`timescale 1ns / 1ps
module sff_sequencer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  sff_pkg::flags_t flags,
  output sff_pkg::ucode_t uw
);

  logic [sff_pkg::STEP_W-1:0] step_r;
  logic [sff_pkg::STEP_W-1:0] step_nxt;
  logic [sff_pkg::STEP_W-1:0] step_inc;

  assign uw       = sff_pkg::ucode(step_r);
  assign step_inc = step_r + sff_pkg::STEP_W'(1);

  always_comb begin
    unique case (uw.cond)
      sff_pkg::C_NEXT:     step_nxt = step_inc;
      sff_pkg::C_GOTO:     step_nxt = uw.target;
      sff_pkg::C_WAIT:     step_nxt = start ? step_inc : uw.target;
      sff_pkg::C_CLR_MORE: step_nxt = flags.clr_last ? step_inc : uw.target;
      sff_pkg::C_OP_RD:    step_nxt = flags.is_rd ? uw.target : step_inc;
      sff_pkg::C_OP_CIRC:  step_nxt = flags.is_circ ? uw.target : step_inc;
      sff_pkg::C_EMPTY:    step_nxt = flags.empty ? uw.target : step_inc;
      sff_pkg::C_X_MORE:   step_nxt = flags.x_more ? uw.target : step_inc;
      sff_pkg::C_Y_MORE:   step_nxt = flags.y_more ? uw.target : step_inc;
      default:             step_nxt = sff_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= sff_pkg::S_CLR;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

/* sv/sff_datapath.sv */
`timescale 1ns / 1ps
module sff_datapath #(
  parameter int MAX_WIDTH  = sff_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sff_pkg::MAX_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  sff_pkg::ucode_t              uw,
  input  logic [sff_pkg::COORD_W-1:0]  eff_w,
  input  logic [sff_pkg::COORD_W-1:0]  eff_h,
  input  logic [1:0]                   in_op,
  input  logic signed [10:0]           in_pos_x,
  input  logic signed [10:0]           in_pos_y,
  input  logic [9:0]                   in_box_w,
  input  logic [9:0]                   in_box_h,
  input  logic [9:0]                   in_radius,
  input  logic [7:0]                   in_red,
  input  logic [7:0]                   in_green,
  input  logic [7:0]                   in_blue,
  output sff_pkg::flags_t              flags,
  output logic [7:0]                   pix_red,
  output logic [7:0]                   pix_green,
  output logic [7:0]                   pix_blue,
  output logic                         coord_ok
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = sff_pkg::COORD_W;
  localparam int BW    = sff_pkg::BND_W;

  logic [23:0] mem [DEPTH];

  logic [1:0]          op_r;
  logic signed [10:0]  px_r, py_r;
  logic [9:0]          w_r, h_r, rad_r;
  logic [23:0]         col_r;
  logic [CW-1:0]       x0_r, x1_r, y0_r, y1_r, x_r, y_r;
  logic                empty_r;
  logic [sff_pkg::RR_W-1:0] rr_r;
  logic [sff_pkg::SQ_W-1:0] dx2_r, dy2_r;
  logic [AW-1:0]       clr_addr_r;
  logic                ok_r;
  logic [23:0]         rd_data_r;

  // bounds
  logic signed [BW-1:0] sx, sy, sw, sh, sr, ew, eh;
  logic signed [BW-1:0] xa, xb, ya, yb, x0, x1, y0, y1;
  logic                 empty;

  always_comb begin
    sx = BW'(px_r);
    sy = BW'(py_r);
    sw = signed'(BW'(w_r));
    sh = signed'(BW'(h_r));
    sr = signed'(BW'(rad_r));
    ew = signed'(BW'(eff_w));
    eh = signed'(BW'(eff_h));
    unique case (op_r)
      sff_pkg::OP_CIRC: begin
        xa = sx - sr; xb = sx + sr + BW'(1);
        ya = sy - sr; yb = sy + sr + BW'(1);
      end
      sff_pkg::OP_FILL: begin
        xa = '0; xb = ew;
        ya = '0; yb = eh;
      end
      default: begin
        xa = sx; xb = sx + sw;
        ya = sy; yb = sy + sh;
      end
    endcase
    x0 = (xa < 0) ? '0 : xa;
    y0 = (ya < 0) ? '0 : ya;
    x1 = (xb > ew) ? ew : xb;
    y1 = (yb > eh) ? eh : yb;
    empty = (x0 >= x1) || (y0 >= y1);
  end

  // squared distances
  logic signed [sff_pkg::DX_W-1:0] dx, dy;
  logic signed [2*sff_pkg::DX_W-1:0] dxsq, dysq;
  logic [sff_pkg::RR_W-1:0] rsq;
  logic [sff_pkg::SQ_W:0]   dsum;
  logic                     in_disc;

  always_comb begin
    dx      = signed'({{(sff_pkg::DX_W-CW){1'b0}}, x_r}) - sff_pkg::DX_W'(px_r);
    dy      = signed'({{(sff_pkg::DX_W-CW){1'b0}}, y_r}) - sff_pkg::DX_W'(py_r);
    dxsq    = dx * dx;
    dysq    = dy * dy;
    rsq     = rad_r * rad_r;
    dsum    = {1'b0, dx2_r} + {1'b0, dy2_r};
    in_disc = dsum <= (sff_pkg::SQ_W+1)'(rr_r);
  end

  // addressing
  logic [AW-1:0] pix_addr, rd_addr, wr_addr;
  logic [23:0]   wr_data;
  logic          wr_en;
  logic          rd_in;

  assign pix_addr = AW'(y_r) * AW'(MAX_WIDTH) + AW'(x_r);
  assign rd_addr  = AW'(py_r[CW-1:0]) * AW'(MAX_WIDTH) + AW'(px_r[CW-1:0]);
  assign wr_addr  = uw.clr ? clr_addr_r : pix_addr;
  assign wr_data  = uw.clr ? sff_pkg::WHITE : col_r;
  assign wr_en    = uw.clr || (uw.wr && (!uw.circ || in_disc));
  assign rd_in    = (px_r >= 0) && (py_r >= 0) &&
                    (px_r < signed'(11'(eff_w))) && (py_r < signed'(11'(eff_h)));

  assign flags.clr_last = clr_addr_r == AW'(DEPTH - 1);
  assign flags.is_rd    = op_r == sff_pkg::OP_READ;
  assign flags.is_circ  = op_r == sff_pkg::OP_CIRC;
  assign flags.empty    = empty_r;
  assign flags.x_more   = ({1'b0, x_r} + (CW+1)'(1)) < {1'b0, x1_r};
  assign flags.y_more   = ({1'b0, y_r} + (CW+1)'(1)) < {1'b0, y1_r};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (uw.rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (uw.clr) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_op;
      px_r  <= in_pos_x;
      py_r  <= in_pos_y;
      w_r   <= in_box_w;
      h_r   <= in_box_h;
      rad_r <= in_radius;
      col_r <= {in_red, in_green, in_blue};
    end
    if (uw.setup) begin
      x0_r    <= x0[CW-1:0];
      x1_r    <= x1[CW-1:0];
      y0_r    <= y0[CW-1:0];
      y1_r    <= y1[CW-1:0];
      empty_r <= empty;
      rr_r    <= rsq;
    end
    if (uw.y_init) begin
      y_r <= y0_r;
    end else if (uw.y_inc) begin
      y_r <= y_r + CW'(1);
    end
    if (uw.x_init) begin
      x_r <= x0_r;
    end else if (uw.x_inc) begin
      x_r <= x_r + CW'(1);
    end
    if (uw.sqy) begin
      dy2_r <= dysq[sff_pkg::SQ_W-1:0];
    end
    if (uw.sqx) begin
      dx2_r <= dxsq[sff_pkg::SQ_W-1:0];
    end
    if (uw.rd) begin
      ok_r <= rd_in;
    end
  end

  assign pix_red   = ok_r ? rd_data_r[23:16] : 8'd0;
  assign pix_green = ok_r ? rd_data_r[15:8]  : 8'd0;
  assign pix_blue  = ok_r ? rd_data_r[7:0]   : 8'd0;
  assign coord_ok  = ok_r;

endmodule

/* sv/shape_fill_frame_buffer_unit.sv */
`timescale 1ns / 1ps
// filled rectangle / circle rasterizer on an rgb frame buffer
// read pixel: after accept, the dispatch, read and output steps run, then back to idle
// rectangle / fill: one write per cycle in a clipped-box row (single memory write port)
// circle: per pixel of the clipped box a squaring step, then a write step if in the disc
// reset: a clearing pass whitens MAX_WIDTH*MAX_HEIGHT words, busy stays high meanwhile
// results are a one-cycle out_valid strobe, the receiver cannot stall
module shape_fill_frame_buffer_unit #(
  parameter int MAX_WIDTH  = sff_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sff_pkg::MAX_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // command channel
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_op,
  input  logic signed [10:0]  in_pos_x,
  input  logic signed [10:0]  in_pos_y,
  input  logic [9:0]          in_box_w,
  input  logic [9:0]          in_box_h,
  input  logic [9:0]          in_radius,
  input  logic [7:0]          in_red,
  input  logic [7:0]          in_green,
  input  logic [7:0]          in_blue,
  // result channel
  output logic                out_valid,
  output logic [7:0]          out_pix_red,
  output logic [7:0]          out_pix_green,
  output logic [7:0]          out_pix_blue,
  output logic                out_coord_ok,
  // configuration
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_wdata
);

  localparam int CW = sff_pkg::COORD_W;

  // active window registers
  logic [CW-1:0] act_w_r, act_h_r;
  logic [CW-1:0] eff_w, eff_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_w_r <= CW'(128);
      act_h_r <= CW'(128);
    end else if (cfg_we) begin
      if (cfg_index == sff_pkg::CFG_ACTIVE_WIDTH) begin
        act_w_r <= cfg_wdata;
      end else begin
        act_h_r <= cfg_wdata;
      end
    end
  end

  // sizes above the buffer are treated as the buffer size
  assign eff_w = (int'(act_w_r) > MAX_WIDTH)  ? CW'(MAX_WIDTH)  : act_w_r;
  assign eff_h = (int'(act_h_r) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : act_h_r;

  sff_pkg::ucode_t uw;
  sff_pkg::flags_t flags;
  logic            accept;

  // a command is taken only in the idle step of the program
  assign busy      = !uw.idle;
  assign accept    = start && uw.idle;
  assign out_valid = uw.out_stb;

  sff_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .flags (flags),
    .uw    (uw)
  );

  sff_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .uw        (uw),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .in_op     (in_op),
    .in_pos_x  (in_pos_x),
    .in_pos_y  (in_pos_y),
    .in_box_w  (in_box_w),
    .in_box_h  (in_box_h),
    .in_radius (in_radius),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .flags     (flags),
    .pix_red   (out_pix_red),
    .pix_green (out_pix_green),
    .pix_blue  (out_pix_blue),
    .coord_ok  (out_coord_ok)
  );

endmodule
